// ===== src/palette_cycle_interpolator_assert.svh =====
// Assertion macros for the palette cycle interpolator.
// PCI_ASSERT checks a property at every clock edge outside reset.
// PCI_ASSERT_NEXT checks that a condition implies another in the following cycle.
`ifndef PALETTE_CYCLE_INTERPOLATOR_ASSERT_SVH
`define PALETTE_CYCLE_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define PCI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PCI_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define PCI_ASSERT(label, clk, rstn, prop, msg)
`define PCI_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif

`endif

// ===== src/pci_pkg.sv =====
`default_nettype none

package pci_pkg;

    localparam int unsigned MAX_COLOURS     = 8;
    localparam int unsigned PHASE_FRAC_BITS = 16;
    localparam int unsigned CHANNEL_BITS    = 8;
    localparam int unsigned NUM_CHANNELS    = 4;
    localparam int unsigned NUM_PAIRS       = MAX_COLOURS / 2;

    localparam int unsigned PHASE_W   = PHASE_FRAC_BITS + 1;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned IDX_W     = $clog2(MAX_COLOURS);
    localparam int unsigned CH_W      = $clog2(NUM_CHANNELS + 1);
    localparam int unsigned CH_IDX_W  = $clog2(NUM_CHANNELS);
    localparam int unsigned ENTRY_W   = NUM_CHANNELS * CHANNEL_BITS;
    localparam int unsigned PAIR_W    = 2 * ENTRY_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned STEP_W    = 16;

    localparam int unsigned MUL_A_W = PHASE_W;
    localparam int unsigned MUL_B_W = CHANNEL_BITS + 1;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W + 1;

    localparam logic [PHASE_W-1:0] PHASE_ONE = {1'b1, {PHASE_FRAC_BITS{1'b0}}};

    typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] rgba_t;
    typedef logic [MAX_COLOURS-1:0][NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] palette_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_MODE    = 3'd0,
        CFG_COLOUR_COUNT = 3'd1,
        CFG_PAIR_0       = 3'd2,
        CFG_PAIR_1       = 3'd3,
        CFG_PAIR_2       = 3'd4,
        CFG_PAIR_3       = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_INDEX,
        ST_FETCH,
        ST_CHAN
    } state_t;

    typedef struct packed {
        logic  load;
        rgba_t rgba;
        logic  finished;
    } result_t;

endpackage

`default_nettype wire

// ===== src/pci_mul.sv =====
`default_nettype none

module pci_mul (
    input  wire logic                                     aclk,
    input  wire logic                                     en,
    input  wire logic        [pci_pkg::MUL_A_W-1:0]       a,
    input  wire logic signed [pci_pkg::MUL_B_W-1:0]       b,
    output      logic signed [pci_pkg::MUL_P_W-1:0]       product
);

    logic signed [pci_pkg::MUL_P_W-1:0] product_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= $signed({1'b0, a}) * b;
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ===== src/pci_seq.sv =====
`default_nettype none

`include "palette_cycle_interpolator_assert.svh"

module pci_seq (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output      logic                               in_ready,
    input  wire logic [pci_pkg::STEP_W-1:0]         step,
    input  wire logic                               loop_mode,
    input  wire logic [pci_pkg::COUNT_W-1:0]        colour_count,
    input  wire pci_pkg::palette_t                  palette,
    input  wire logic                               out_free,
    output      pci_pkg::result_t                   res
);

    pci_pkg::state_t state_reg, state_next;

    logic [pci_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                        done_reg, done_next;
    logic [pci_pkg::CH_W-1:0]    ch_reg, ch_next;

    logic [pci_pkg::PHASE_FRAC_BITS-1:0]                       t_reg;
    logic [pci_pkg::IDX_W-1:0]                                 idx2_reg;
    pci_pkg::rgba_t                                            e1_reg, e2_reg;
    logic [pci_pkg::NUM_CHANNELS-2:0][pci_pkg::CHANNEL_BITS-1:0] chan_reg;

    logic                               accept;
    logic [pci_pkg::COUNT_W-1:0]        cnt;
    logic [pci_pkg::COUNT_W-1:0]        last;
    logic [pci_pkg::PHASE_W-1:0]        sum;
    logic                               wrapped;

    logic signed [pci_pkg::MUL_P_W-1:0] product;
    logic [pci_pkg::COUNT_W-1:0]        prod_idx;
    logic [pci_pkg::COUNT_W-1:0]        prod_inc;
    logic                               clamp_seg;
    logic [pci_pkg::COUNT_W-1:0]        i1, i2;
    logic [pci_pkg::IDX_W-1:0]          rd_addr;
    pci_pkg::rgba_t                     rd_entry;

    logic [pci_pkg::CH_IDX_W-1:0]       issue_ch, prev_ch;
    logic [pci_pkg::CHANNEL_BITS-1:0]   c1, c2, c1_prev;
    logic signed [pci_pkg::MUL_B_W-1:0] diff;
    logic [pci_pkg::MUL_P_W-1:0]        acc;
    logic [pci_pkg::CHANNEL_BITS-1:0]   chan_out;
    logic                               chan_busy;
    logic                               chan_last;

    logic                               mul_en;
    logic                               mul_sel_chan;
    logic [pci_pkg::MUL_A_W-1:0]        mul_a;
    logic signed [pci_pkg::MUL_B_W-1:0] mul_b;

    // Datapath
    always_comb begin
        priority if (colour_count == '0) begin
            cnt = pci_pkg::COUNT_W'(1);
        end else if (colour_count > pci_pkg::COUNT_W'(pci_pkg::MAX_COLOURS)) begin
            cnt = pci_pkg::COUNT_W'(pci_pkg::MAX_COLOURS);
        end else begin
            cnt = colour_count;
        end
    end

    assign last    = cnt - pci_pkg::COUNT_W'(1);
    assign accept  = in_valid && in_ready;
    assign sum     = phase_reg + {1'b0, step};
    assign wrapped = sum[pci_pkg::PHASE_FRAC_BITS];

    always_comb begin
        phase_next = phase_reg;
        done_next  = done_reg;
        if (accept) begin
            done_next = !loop_mode && wrapped;
            priority if (!wrapped) begin
                phase_next = sum;
            end else if (loop_mode) begin
                phase_next = {1'b0, sum[pci_pkg::PHASE_FRAC_BITS-1:0]};
            end else begin
                phase_next = pci_pkg::PHASE_ONE;
            end
        end
    end

    assign prod_idx  = product[pci_pkg::PHASE_FRAC_BITS +: pci_pkg::COUNT_W];
    assign prod_inc  = prod_idx + pci_pkg::COUNT_W'(1);
    assign clamp_seg = !loop_mode && (prod_idx >= last);

    always_comb begin
        if (clamp_seg) begin
            i1 = last;
            i2 = last;
        end else begin
            i1 = prod_idx;
            i2 = (prod_inc == cnt) ? '0 : prod_inc;
        end
    end

    assign rd_addr  = (state_reg == pci_pkg::ST_INDEX) ? i1[pci_pkg::IDX_W-1:0] : idx2_reg;
    assign rd_entry = palette[rd_addr];

    assign issue_ch = ch_reg[pci_pkg::CH_IDX_W-1:0];
    assign prev_ch  = issue_ch - pci_pkg::CH_IDX_W'(1);
    assign c1       = e1_reg[issue_ch];
    assign c2       = e2_reg[issue_ch];
    assign c1_prev  = e1_reg[prev_ch];
    assign diff     = $signed({1'b0, c2}) - $signed({1'b0, c1});
    assign acc      = pci_pkg::MUL_P_W'({c1_prev, {pci_pkg::PHASE_FRAC_BITS{1'b0}}})
                    + pci_pkg::MUL_P_W'(product);
    assign chan_out = acc[pci_pkg::PHASE_FRAC_BITS +: pci_pkg::CHANNEL_BITS];

    assign chan_busy = (ch_reg < pci_pkg::CH_W'(pci_pkg::NUM_CHANNELS));
    assign chan_last = (ch_reg == pci_pkg::CH_W'(pci_pkg::NUM_CHANNELS));

    assign mul_a = mul_sel_chan ? {1'b0, t_reg} : phase_reg;
    assign mul_b = mul_sel_chan ? diff
                 : $signed({{(pci_pkg::MUL_B_W - pci_pkg::COUNT_W){1'b0}}, cnt});

    pci_mul u_mul (
        .aclk    (aclk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pci_pkg::ST_IDLE:  if (accept) state_next = pci_pkg::ST_PROD;
            pci_pkg::ST_PROD:  state_next = pci_pkg::ST_INDEX;
            pci_pkg::ST_INDEX: state_next = pci_pkg::ST_FETCH;
            pci_pkg::ST_FETCH: state_next = pci_pkg::ST_CHAN;
            pci_pkg::ST_CHAN:  if (chan_last && out_free) state_next = pci_pkg::ST_IDLE;
            default:           state_next = pci_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        in_ready     = 1'b0;
        mul_en       = 1'b0;
        mul_sel_chan = 1'b0;
        res.load     = 1'b0;
        ch_next      = ch_reg;
        for (int k = 0; k < pci_pkg::NUM_CHANNELS - 1; k++) begin
            res.rgba[k] = chan_reg[k];
        end
        res.rgba[pci_pkg::NUM_CHANNELS-1] = chan_out;
        res.finished = done_reg;
        unique case (state_reg)
            pci_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            pci_pkg::ST_PROD: begin
                mul_en = 1'b1;
            end
            pci_pkg::ST_INDEX: begin
            end
            pci_pkg::ST_FETCH: begin
                ch_next = '0;
            end
            pci_pkg::ST_CHAN: begin
                mul_sel_chan = 1'b1;
                mul_en       = chan_busy;
                res.load     = chan_last && out_free;
                if (chan_busy) begin
                    ch_next = ch_reg + pci_pkg::CH_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pci_pkg::ST_IDLE;
            phase_reg <= '0;
            done_reg  <= 1'b0;
            ch_reg    <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            ch_reg    <= ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == pci_pkg::ST_INDEX) begin
            t_reg    <= product[pci_pkg::PHASE_FRAC_BITS-1:0];
            idx2_reg <= i2[pci_pkg::IDX_W-1:0];
            e1_reg   <= rd_entry;
        end
        if (state_reg == pci_pkg::ST_FETCH) begin
            e2_reg <= rd_entry;
        end
        if (state_reg == pci_pkg::ST_CHAN && chan_busy && ch_reg != '0) begin
            chan_reg[prev_ch] <= chan_out;
        end
    end

    `PCI_ASSERT(a_phase_bound, aclk, aresetn, phase_reg <= pci_pkg::PHASE_ONE, "phase above one")
    `PCI_ASSERT_NEXT(a_loop_wrap, aclk, aresetn, accept && loop_mode, phase_reg < pci_pkg::PHASE_ONE, "loop phase not wrapped")
    `PCI_ASSERT_NEXT(a_busy, aclk, aresetn, accept, !in_ready, "ready right after accept")
    `PCI_ASSERT(a_done_phase, aclk, aresetn, !done_reg || (phase_reg == pci_pkg::PHASE_ONE), "done without full phase")
    `PCI_ASSERT(a_fin_oneshot, aclk, aresetn, !(res.load && res.finished) || !loop_mode, "finished in loop mode")

endmodule

`default_nettype wire

// ===== src/palette_cycle_interpolator.sv =====
// Palette cycle interpolator.
// Input stream (s_): each beat carries a 16-bit phase step that advances
// an unsigned Q1.16 phase. Output stream (m_): one beat per input beat with
// the blended RGBA8 colour in m_tdata and the one-shot finished flag in m_tuser.
// Configuration: cfg_we writes register cfg_index with cfg_wdata;
// index 0 loop mode, 1 colour count, 2..5 palette pairs. Write only while idle.
// Flow: s_tready is high only while the sequencer is idle, so a beat is not
// taken until the previous beat's result has been loaded into the output
// register. Each beat steps through the states PROD, INDEX, FETCH and CHAN on
// the shared 17x9 multiplier: one pass for phase times colour count, then one
// pass per colour channel, with the palette read one entry per cycle.
// Stall: the result waits in the output register while m_tready is low; the
// next beat is still accepted and its work runs up to the last channel, then
// holds until the output register frees up.
// Reset: aresetn (synchronous, active low) clears the phase to 0, drops
// m_tvalid, and sets loop mode 1, colour count 1 and all palette entries to 0.
`default_nettype none

module palette_cycle_interpolator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [15:0]                       s_tdata,   // phase_step
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic [31:0]                       m_tdata,   // red, green, blue, alpha
    output      logic [0:0]                        m_tuser,   // finished
    input  wire logic                              cfg_we,
    input  wire logic [pci_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pci_pkg::PAIR_W-1:0]        cfg_wdata
);

    logic                        loop_mode_reg;
    logic [pci_pkg::COUNT_W-1:0] count_reg;
    pci_pkg::palette_t           pal_reg;

    logic                        m_tvalid_reg;
    pci_pkg::rgba_t              m_tdata_reg;
    logic                        m_tuser_reg;

    logic                        out_free;
    pci_pkg::result_t            res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_mode_reg <= 1'b1;
            count_reg     <= pci_pkg::COUNT_W'(1);
            pal_reg       <= '0;
        end else if (cfg_we) begin
            unique case (pci_pkg::cfg_idx_t'(cfg_index))
                pci_pkg::CFG_LOOP_MODE:    loop_mode_reg <= cfg_wdata[0];
                pci_pkg::CFG_COLOUR_COUNT: count_reg     <= cfg_wdata[pci_pkg::COUNT_W-1:0];
                pci_pkg::CFG_PAIR_0:       pal_reg[1:0]  <= cfg_wdata;
                pci_pkg::CFG_PAIR_1:       pal_reg[3:2]  <= cfg_wdata;
                pci_pkg::CFG_PAIR_2:       pal_reg[5:4]  <= cfg_wdata;
                pci_pkg::CFG_PAIR_3:       pal_reg[7:6]  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    pci_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .step         (s_tdata),
        .loop_mode    (loop_mode_reg),
        .colour_count (count_reg),
        .palette      (pal_reg),
        .out_free     (out_free),
        .res          (res)
    );

    // Hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            m_tdata_reg <= res.rgba;
            m_tuser_reg <= res.finished;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
